// ===== design/sdtq_pkg.sv =====
// ----------------------------------------------------------------------------
// sdtq_pkg: shared types and constants for the sorted deadline timer queue
// Queue depth, index widths, operation and status codes, and the structs
// that run between the sequencer and the entry store.
// ----------------------------------------------------------------------------
`default_nettype none

package sdtq_pkg;

  // Queue geometry
  localparam int unsigned DEPTH   = 16;
  localparam int unsigned MAX_OUT = 16;   // expiries reported per tick
  localparam int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned NW      = $clog2(MAX_OUT + 1);

  // Field widths
  localparam int unsigned ID_W    = 8;
  localparam int unsigned DLY_W   = 32;
  localparam int unsigned DL_W    = 64;

  // Operation codes
  typedef enum logic [1:0] {
    FUNC_ADD  = 2'd0,
    FUNC_DEL  = 2'd1,
    FUNC_TICK = 2'd2
  } func_e;

  // Result status codes
  typedef enum logic [2:0] {
    RES_OK      = 3'd0,
    RES_FULL    = 3'd1,
    RES_DUP     = 3'd2,
    RES_MISSING = 3'd3,
    RES_EXPIRED = 3'd4
  } event_res_e;

  // Entry store write port
  typedef struct packed {
    logic            en;
    logic [AW-1:0]   addr;
    logic [DL_W-1:0] dl;
    logic [ID_W-1:0] id;
  } store_wr_t;

  // Entry store read data
  typedef struct packed {
    logic [DL_W-1:0] dl;
    logic [ID_W-1:0] id;
  } store_rd_t;

endpackage

`default_nettype wire

// ===== design/sdtq_in_if.sv =====
// ----------------------------------------------------------------------------
// sdtq_in_if: request channel of the timer queue
// Valid/ready channel carrying one operation: add, delete or tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdtq_in_if;

  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  timer_id;
  logic [31:0] delay;

  modport source (output valid, func, timer_id, delay, input ready);
  modport sink   (input valid, func, timer_id, delay, output ready);

endinterface

`default_nettype wire

// ===== design/sdtq_out_if.sv =====
// ----------------------------------------------------------------------------
// sdtq_out_if: result channel of the timer queue
// Valid/ready channel carrying one status or expiry item.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdtq_out_if;

  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [7:0]  timer_id_res;
  logic [63:0] deadline;
  logic        last;

  modport source (output valid, event_res, timer_id_res, deadline, last, input ready);
  modport sink   (input valid, event_res, timer_id_res, deadline, last, output ready);

endinterface

`default_nettype wire

// ===== design/sdtq_store.sv =====
// ----------------------------------------------------------------------------
// sdtq_store: timer entry memory
// DEPTH entries of deadline and id, one write port and one read port with
// registered read data. Contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module sdtq_store
  import sdtq_pkg::*;
(
  input  wire logic          clk_i,
  input  wire store_wr_t     wr_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output store_rd_t          rd_o
);

  logic [DL_W-1:0] dl_mem [DEPTH];
  logic [ID_W-1:0] id_mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      dl_mem[wr_i.addr] <= wr_i.dl;
      id_mem[wr_i.addr] <= wr_i.id;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rd_o.dl <= dl_mem[rd_addr_i];
    rd_o.id <= id_mem[rd_addr_i];
  end

endmodule

`default_nettype wire

// ===== design/sorted_deadline_timer_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_deadline_timer_queue: deadline-sorted software timer list
// Up to DEPTH timers held in ascending deadline order, plus a tick counter.
// ----------------------------------------------------------------------------
// Usage: the block takes one item at a time and drops ready until its final
// result is loaded into the output register. All list work goes through one
// entry memory with a registered read port; each entry touched is read, then
// compared or written back. An add scans the list for the id and the insert
// position, then shifts entries up to open the slot. A delete scan stops at
// the match, and the shift down covers the rest of the list. A tick checks
// the head against the new time; each expiry removes the head. A busy result
// channel stalls the block. Add and delete return one status item; a tick
// returns one item per expired timer (up to MAX_OUT) with the final one
// flagged last, or nothing. There is no clearing pass after reset.
`default_nettype none

module sorted_deadline_timer_queue
  import sdtq_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sdtq_in_if.sink   in_i,
  sdtq_out_if.source out_o
);

  // Sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN_RD  = 4'd1;
  localparam logic [3:0] S_SCAN_CMP = 4'd2;
  localparam logic [3:0] S_INS_RD   = 4'd3;
  localparam logic [3:0] S_INS_WR   = 4'd4;
  localparam logic [3:0] S_RMV_RD   = 4'd5;
  localparam logic [3:0] S_RMV_WR   = 4'd6;
  localparam logic [3:0] S_TICK_RD  = 4'd7;
  localparam logic [3:0] S_TICK_CMP = 4'd8;
  localparam logic [3:0] S_EMIT     = 4'd9;

  localparam logic [DL_W-1:0] ALL_ONES = '1;

  logic [3:0]       state_q, state_d;
  func_e            op_q, op_d;
  logic [ID_W-1:0]  id_q, id_d;
  logic [DL_W-1:0]  dl_q, dl_d;
  logic [DL_W-1:0]  now_q, now_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic             found_q, found_d;
  logic [NW-1:0]    n_q, n_d;
  logic             hold_q, hold_d;
  event_res_e       res_code_q, res_code_d;
  logic [ID_W-1:0]  res_id_q, res_id_d;
  logic [DL_W-1:0]  res_dl_q, res_dl_d;

  logic             out_vld_q;
  logic [2:0]       out_res_q;
  logic [ID_W-1:0]  out_id_q;
  logic [DL_W-1:0]  out_dl_q;
  logic             out_last_q;

  logic             out_free;
  logic             out_load;
  logic             out_last;
  logic             in_acc;
  logic [DL_W:0]    dl_sum;
  logic [DL_W-1:0]  dl_sat;
  logic [CNT_W-1:0] idx_inc;
  logic [CNT_W-1:0] idx_dec;

  store_wr_t        wr;
  logic [AW-1:0]    rd_addr;
  store_rd_t        rd;

  sdtq_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_o      (rd)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_vld_q || out_o.ready;

  // Saturating deadline add
  assign dl_sum = {1'b0, now_q} + {{(DL_W + 1 - DLY_W){1'b0}}, in_i.delay};
  assign dl_sat = dl_sum[DL_W] ? ALL_ONES : dl_sum[DL_W-1:0];

  assign idx_inc = idx_q + CNT_W'(1);
  assign idx_dec = idx_q - CNT_W'(1);

  // Sequencer
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    id_d       = id_q;
    dl_d       = dl_q;
    now_d      = now_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    pos_d      = pos_q;
    found_d    = found_q;
    n_d        = n_q;
    hold_d     = hold_q;
    res_code_d = res_code_q;
    res_id_d   = res_id_q;
    res_dl_d   = res_dl_q;
    out_load   = 1'b0;
    out_last   = 1'b1;
    rd_addr    = '0;
    wr.en      = 1'b0;
    wr.addr    = idx_q[AW-1:0];
    wr.dl      = rd.dl;
    wr.id      = rd.id;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d    = func_e'(in_i.func);
          id_d    = in_i.timer_id;
          dl_d    = dl_sat;
          idx_d   = '0;
          pos_d   = cnt_q;
          found_d = 1'b0;
          n_d     = '0;
          hold_d  = 1'b0;
          case (in_i.func)
            FUNC_ADD, FUNC_DEL: state_d = S_SCAN_RD;
            FUNC_TICK: begin
              if (now_q != ALL_ONES) now_d = now_q + DL_W'(1);
              state_d = S_TICK_RD;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      // Walk the list looking for the id and, on add, the insert slot
      S_SCAN_RD: begin
        rd_addr = idx_q[AW-1:0];
        if (idx_q == cnt_q) begin
          res_id_d = id_q;
          if (op_q == FUNC_ADD) begin
            if (cnt_q == CNT_W'(DEPTH)) begin
              res_code_d = RES_FULL;
              res_dl_d   = '0;
              state_d    = S_EMIT;
            end else begin
              idx_d   = cnt_q;
              state_d = S_INS_RD;
            end
          end else begin
            res_code_d = RES_MISSING;
            res_dl_d   = '0;
            state_d    = S_EMIT;
          end
        end else begin
          state_d = S_SCAN_CMP;
        end
      end

      S_SCAN_CMP: begin
        res_id_d = id_q;
        if (rd.id == id_q) begin
          if (op_q == FUNC_ADD) begin
            res_code_d = RES_DUP;
            res_dl_d   = '0;
            state_d    = S_EMIT;
          end else begin
            res_code_d = RES_OK;
            res_dl_d   = rd.dl;
            state_d    = S_RMV_RD;
          end
        end else begin
          if (!found_q && rd.dl >= dl_q) begin
            pos_d   = idx_q;
            found_d = 1'b1;
          end
          idx_d   = idx_inc;
          state_d = S_SCAN_RD;
        end
      end

      // Shift entries up from the tail down to the insert slot
      S_INS_RD: begin
        rd_addr = idx_dec[AW-1:0];
        if (idx_q == pos_q) begin
          wr.en      = 1'b1;
          wr.dl      = dl_q;
          wr.id      = id_q;
          cnt_d      = cnt_q + CNT_W'(1);
          res_code_d = RES_OK;
          res_id_d   = id_q;
          res_dl_d   = dl_q;
          state_d    = S_EMIT;
        end else begin
          state_d = S_INS_WR;
        end
      end

      S_INS_WR: begin
        wr.en   = 1'b1;
        idx_d   = idx_dec;
        state_d = S_INS_RD;
      end

      // Close the gap at idx by shifting the tail down one slot
      S_RMV_RD: begin
        rd_addr = idx_inc[AW-1:0];
        if (idx_inc >= cnt_q) begin
          cnt_d   = cnt_q - CNT_W'(1);
          state_d = (op_q == FUNC_TICK) ? S_TICK_RD : S_EMIT;
        end else begin
          state_d = S_RMV_WR;
        end
      end

      S_RMV_WR: begin
        wr.en   = 1'b1;
        idx_d   = idx_inc;
        state_d = S_RMV_RD;
      end

      // Check the head against the new time
      S_TICK_RD: begin
        if (n_q == NW'(MAX_OUT) || cnt_q == '0) begin
          state_d = hold_q ? S_EMIT : S_IDLE;
        end else begin
          state_d = S_TICK_CMP;
        end
      end

      S_TICK_CMP: begin
        if (rd.dl <= now_q) begin
          // the held expiry goes out as not-last once the next one is known
          if (!hold_q || out_free) begin
            out_load   = hold_q;
            out_last   = 1'b0;
            hold_d     = 1'b1;
            res_code_d = RES_EXPIRED;
            res_id_d   = rd.id;
            res_dl_d   = rd.dl;
            n_d        = n_q + NW'(1);
            idx_d      = '0;
            state_d    = S_RMV_RD;
          end
        end else begin
          state_d = hold_q ? S_EMIT : S_IDLE;
        end
      end

      // Final item of this operation
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      now_q   <= '0;
      cnt_q   <= '0;
      hold_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      now_q   <= now_d;
      cnt_q   <= cnt_d;
      hold_q  <= hold_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    id_q       <= id_d;
    dl_q       <= dl_d;
    idx_q      <= idx_d;
    pos_q      <= pos_d;
    found_q    <= found_d;
    n_q        <= n_d;
    res_code_q <= res_code_d;
    res_id_q   <= res_id_d;
    res_dl_q   <= res_dl_d;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_res_q  <= res_code_q;
      out_id_q   <= res_id_q;
      out_dl_q   <= res_dl_q;
      out_last_q <= out_last;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.event_res    = out_res_q;
  assign out_o.timer_id_res = out_id_q;
  assign out_o.deadline     = out_dl_q;
  assign out_o.last         = out_last_q;

endmodule

`default_nettype wire
